/* hw/rtl/gpsp_pkg.sv */
`default_nettype none

package gpsp_pkg;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_STROBE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_PAD_COUNT   = 2'd0,
    CFG_SECOND_MASK = 2'd1,
    CFG_SWAP        = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  localparam int CfgDataW = 8;

  localparam logic [2:0] PadCountReset  = 3'd2;
  localparam logic [7:0] SecondMaskReset = 8'hF3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] host_keys;
    logic        strobe_bit;
    logic        port;
  } in_word_t;

  typedef struct packed {
    logic [1:0] read_data;
  } out_word_t;

  // live configuration, with the pad count already clipped to the pad slots
  typedef struct packed {
    logic [2:0] act;
    logic [7:0] mask;
    logic       swap;
  } cfg_t;

  // control from the front end to the serial shifters
  typedef struct packed {
    logic rd_en;
    logic port;
    logic clear;
  } rd_ctl_t;

  // host bit order to console button order
  function automatic logic [7:0] remap_buttons(input logic [7:0] b);
    remap_buttons = (b & 8'h0F) | ((b >> 2) & 8'h30) | ((b << 1) & 8'h40)
                  | ((b << 3) & 8'h80);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/gpsp_chan_if.sv */
`default_nettype none

interface gpsp_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/gpsp_pad_regs.sv */
`default_nettype none

module gpsp_pad_regs #(
  parameter int PADS = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire gpsp_pkg::in_word_t  word,
  input  wire gpsp_pkg::cfg_t      cfg,
  output logic [PADS-1:0][7:0]     pad_bytes,
  output logic                     clear
);
  import gpsp_pkg::*;

  logic                  latch_on;
  logic                  latch_on_next;
  logic [PADS-1:0][7:0]  host_bytes;
  logic [PADS-1:0][7:0]  host_bytes_next;
  logic [31:0]           keys;
  logic                  is_update;
  logic                  is_strobe;

  always_comb begin
    is_update = accept && (word.op == OP_UPDATE);
    is_strobe = accept && (word.op == OP_STROBE);
    keys = cfg.swap ? {word.host_keys[23:0], 8'h00} : word.host_keys;
    host_bytes_next = host_bytes;
    if (is_update) begin
      for (int n = 0; n < PADS; n++) begin
        if (3'(n) < cfg.act) begin
          host_bytes_next[n] = keys[8*n +: 8];
        end
      end
      // pad 1 mask applies even when pad 1 is not loaded
      host_bytes_next[1] = host_bytes_next[1] & cfg.mask;
    end
    latch_on_next = is_strobe ? word.strobe_bit : latch_on;
    clear = (is_update || is_strobe) && latch_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch_on   <= 1'b0;
      host_bytes <= '0;
      pad_bytes  <= '0;
    end else begin
      latch_on   <= latch_on_next;
      host_bytes <= host_bytes_next;
      if (clear) begin
        for (int n = 0; n < PADS; n++) begin
          if (3'(n) < cfg.act) begin
            pad_bytes[n] <= remap_buttons(host_bytes_next[n]);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/gpsp_serial.sv */
`default_nettype none

module gpsp_serial #(
  parameter int PADS = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire gpsp_pkg::rd_ctl_t   ctl,
  input  wire logic [2:0]          act,
  input  wire logic [PADS-1:0][7:0] pad_bytes,
  output logic [1:0]               read_data
);
  import gpsp_pkg::*;

  logic [1:0][3:0] bits_sent;
  logic [3:0]      pos;
  logic [7:0]      main_byte;
  logic [7:0]      extra_byte;
  logic            has_extra;
  logic            has_main;

  always_comb begin
    pos        = bits_sent[ctl.port];
    main_byte  = ctl.port ? pad_bytes[1] : pad_bytes[0];
    extra_byte = 8'h00;
    for (int i = 2; i < PADS; i++) begin
      if (1'(i - 2) == ctl.port) begin
        extra_byte = pad_bytes[i];
      end
    end
    has_extra = act > (3'(ctl.port) + 3'd2);
    has_main  = act > 3'(ctl.port);
    read_data = 2'b00;
    if (ctl.rd_en) begin
      if (pos[3]) begin
        // past the eighth bit: report which pads are attached
        if (has_extra) begin
          read_data = 2'b11;
        end else if (has_main) begin
          read_data = 2'b01;
        end
      end else begin
        read_data[0] = main_byte[pos[2:0]];
        read_data[1] = has_extra && extra_byte[pos[2:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_sent <= '0;
    end else if (ctl.clear) begin
      bits_sent <= '0;
    end else if (ctl.rd_en && !pos[3]) begin
      bits_sent[ctl.port] <= pos + 4'd1;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/game_pad_serial_port_core.sv */
`default_nettype none

// Channel  Dir  Word        Fields
// -------  ---  ----------  --------------------------------------
// req      in   in_word_t   op, host_keys, strobe_bit, port
// rsp      out  out_word_t  read_data (one word per req word)
// cfg      in   write only  cfg_we, cfg_index, cfg_data
//
// One req word per cycle unless rsp stalls: state updates at the accepting
// edge and the answer lands in the rsp register on that same edge.
// req.ready drops only while rsp holds a word the sink is not taking.
// rst is synchronous: pad count 2, pad 1 mask 0xF3, no swap, all pad
// bytes, counters and the latch cleared.

module game_pad_serial_port_core #(
  parameter int PADS = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [gpsp_pkg::CfgDataW-1:0] cfg_data,
  gpsp_chan_if.sink                        req,
  gpsp_chan_if.source                      rsp
);
  import gpsp_pkg::*;

  // configuration registers
  logic [2:0] pad_count;
  logic [7:0] second_pad_mask;
  logic       swap_players;

  cfg_t                 cfg;
  rd_ctl_t              rd_ctl;
  logic                 accept;
  logic                 clear;
  logic [PADS-1:0][7:0] pad_bytes;
  logic [1:0]           read_data;

  // rsp output register
  logic       rsp_valid;
  out_word_t  rsp_word;
  in_word_t   req_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_count       <= PadCountReset;
      second_pad_mask <= SecondMaskReset;
      swap_players    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PAD_COUNT:   pad_count       <= cfg_data[2:0];
        CFG_SECOND_MASK: second_pad_mask <= cfg_data[7:0];
        CFG_SWAP:        swap_players    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    req_word = req.data;
    // active pads never exceed the pad slots built
    cfg.act  = (pad_count > 3'(PADS)) ? 3'(PADS) : pad_count;
    cfg.mask = second_pad_mask;
    cfg.swap = swap_players;
    req.ready = !rsp_valid || rsp.ready;
    accept    = req.valid && req.ready;
    rd_ctl.rd_en = accept && (req_word.op == OP_READ);
    rd_ctl.port  = req_word.port;
    rd_ctl.clear = clear;
  end

  gpsp_pad_regs #(
    .PADS(PADS)
  ) u_pad_regs (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .word      (req_word),
    .cfg       (cfg),
    .pad_bytes (pad_bytes),
    .clear     (clear)
  );

  gpsp_serial #(
    .PADS(PADS)
  ) u_serial (
    .clk       (clk),
    .rst       (rst),
    .ctl       (rd_ctl),
    .act       (cfg.act),
    .pad_bytes (pad_bytes),
    .read_data (read_data)
  );

  // every accepted word yields exactly one rsp word
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_word.read_data <= read_data;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_word;

endmodule

`default_nettype wire

/* tb/game_pad_serial_port_core_tb.sv */
`timescale 1ns / 1ps

module game_pad_serial_port_core_tb;
  import gpsp_pkg::*;

  localparam int PADS        = 4;
  localparam int STUCK_LIMIT = 1000;   // cycles with no handshake and no register write
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 80;

  // One directed row: a request word, and the answer when it is obvious.
  // Rows with known == 0 are scored against the pad model instead.
  typedef struct packed {
    in_word_t   w;
    logic       known;
    logic [1:0] want;
  } row_t;

  // Directed rows, run with the reset configuration (2 pads, mask 0xF3, no swap).
  localparam row_t DIRECTED_ROWS [23] = '{
    '{'{OP_READ,   32'h0000_0000, 1'b0, 1'b0}, 1'b1, 2'd0},  // read before anything loaded
    '{'{OP_READ,   32'h0000_0000, 1'b0, 1'b1}, 1'b1, 2'd0},
    '{'{OP_UPDATE, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b1, 2'd0},  // all keys down
    '{'{OP_STROBE, 32'h0000_0000, 1'b1, 1'b0}, 1'b1, 2'd0},  // latch on, pads reload
    '{'{OP_READ,   32'h0000_0000, 1'b0, 1'b0}, 1'b0, 2'd0},
    '{'{OP_READ,   32'h0000_0000, 1'b0, 1'b1}, 1'b0, 2'd0},  // masked second pad
    '{'{OP_UPDATE, 32'h0000_0000, 1'b0, 1'b0}, 1'b1, 2'd0},  // latch still on
    '{'{OP_READ,   32'h0000_0000, 1'b0, 1'b0}, 1'b0, 2'd0},
    '{'{OP_UPDATE, 32'hA5A5_5A5A, 1'b0, 1'b0}, 1'b1, 2'd0},
    '{'{OP_STROBE, 32'h0000_0000, 1'b0, 1'b0}, 1'b1, 2'd0},  // latch off, nothing else moves
    '{'{OP_UPDATE, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b1, 2'd0},  // pads keep old bytes
    '{'{OP_READ,   32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b0, 2'd0},
    '{'{OP_NONE,   32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b1, 2'd0},  // unused op is a no-op
    '{'{OP_STROBE, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b1, 2'd0},
    '{'{OP_READ,   32'h0000_0000, 1'b0, 1'b0}, 1'b0, 2'd0},  // walk all eight bits ...
    '{'{OP_READ,   32'h0000_0000, 1'b0, 1'b0}, 1'b0, 2'd0},
    '{'{OP_READ,   32'h0000_0000, 1'b0, 1'b0}, 1'b0, 2'd0},
    '{'{OP_READ,   32'h0000_0000, 1'b0, 1'b0}, 1'b0, 2'd0},
    '{'{OP_READ,   32'h0000_0000, 1'b0, 1'b0}, 1'b0, 2'd0},
    '{'{OP_READ,   32'h0000_0000, 1'b0, 1'b0}, 1'b0, 2'd0},
    '{'{OP_READ,   32'h0000_0000, 1'b0, 1'b0}, 1'b0, 2'd0},
    '{'{OP_READ,   32'h0000_0000, 1'b0, 1'b0}, 1'b0, 2'd0},
    '{'{OP_READ,   32'h0000_0000, 1'b0, 1'b0}, 1'b0, 2'd0}   // ... and one past the end
  };

  // Register settings per phase; the last phase is drawn at random.
  localparam logic [2:0] PHASE_PADS [PHASES] = '{3'd4, 3'd4, 3'd0, 3'd1,
                                                 3'd3, 3'd4, 3'd2, 3'd2};
  localparam logic [7:0] PHASE_MASK [PHASES] = '{8'hFF, 8'h00, 8'h5A, 8'hFF,
                                                 8'hA5, 8'hF3, 8'h00, 8'hC3};
  localparam logic       PHASE_SWAP [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1,
                                                 1'b0, 1'b1, 1'b1, 1'b0};

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  gpsp_chan_if #(.T(in_word_t))  req_ch ();
  gpsp_chan_if #(.T(out_word_t)) rsp_ch ();

  game_pad_serial_port_core #(
    .PADS(PADS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Pad model: own copy of the registers and of the port state.
  // ---------------------------------------------------------------------------
  logic [2:0] cfg_pads;
  logic [7:0] cfg_mask;
  logic       cfg_swap;
  logic       latch_set;
  logic [7:0] host_byte [PADS];
  logic [7:0] pad_byte  [PADS];
  logic [3:0] sent      [2];

  logic [1:0] pad_answers [$];   // expected read_data, oldest first
  int         bad_words;
  bit         req_up;            // req.valid is currently driven high
  bit         quiet_tx;          // sender runs back to back while set
  bit         quiet_rx;          // receiver never stalls while set
  int         stuck;

  function automatic int pads_in_use();
    return (cfg_pads < PADS) ? int'(cfg_pads) : PADS;
  endfunction

  // host order -> console order: bits 7:6 drop to 5:4, bit 5 -> 6, bit 4 -> 7
  function automatic logic [7:0] console_order(logic [7:0] b);
    return {b[4], b[5], b[7:6], b[3:0]};
  endfunction

  // while the latch is high, every update or strobe reloads the shifters
  function automatic void reload_pads();
    if (latch_set) begin
      sent[0] = '0;
      sent[1] = '0;
      for (int n = 0; n < pads_in_use(); n++)
        pad_byte[n] = console_order(host_byte[n]);
    end
  endfunction

  // Advance the pad model by one request word and return its read_data.
  function automatic logic [1:0] step_pads(in_word_t w);
    logic [31:0] keys;
    logic [1:0]  ans;
    int          act;
    int          p;
    int          pos;
    act = pads_in_use();
    p   = int'(w.port);
    ans = '0;
    case (w.op)
      OP_UPDATE: begin
        keys = cfg_swap ? {w.host_keys[23:0], 8'h00} : w.host_keys;
        for (int n = 0; n < act; n++)
          host_byte[n] = keys[8*n +: 8];
        host_byte[1] = host_byte[1] & cfg_mask;   // masked even with < 2 pads
        reload_pads();
      end
      OP_STROBE: begin
        latch_set = w.strobe_bit;
        reload_pads();
      end
      OP_READ: begin
        pos = int'(sent[p]);
        if (pos >= 8) begin
          // shifter exhausted: counter holds, answer tells pads present
          if (act > p + 2)  ans = 2'd3;
          else if (act > p) ans = 2'd1;
        end else begin
          ans[0] = pad_byte[p][pos];
          if (act > p + 2) ans[1] = pad_byte[p + 2][pos];
          sent[p] = 4'(pos + 1);
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  function automatic int pick_wait(bit hush);
    return hush ? 0 : $urandom_range(0, 19);
  endfunction

  // request word of the given op, every other field random
  function automatic in_word_t make_word(logic [1:0] op);
    in_word_t w;
    w.op         = op;
    w.host_keys  = $urandom;
    w.strobe_bit = 1'($urandom_range(0, 1));
    w.port       = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  in_word_t phase_words [$];

  task automatic send_word(in_word_t w, logic known, logic [1:0] want);
    int         gap;
    logic [1:0] guess;
    if ($urandom_range(0, 39) == 0) quiet_tx = !quiet_tx;
    gap = pick_wait(quiet_tx);
    if (gap > 0) begin
      if (req_up) req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= w;
    req_up = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    // accepted at this edge: state moves now, answer follows on rsp
    guess = step_pads(w);
    pad_answers.push_back(known ? want : guess);
  endtask

  // drop valid and wait until every answer is home
  task automatic settle();
    if (req_up) req_ch.valid <= 1'b0;
    req_up = 1'b0;
    while (pad_answers.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_PAD_COUNT:   cfg_pads = val[2:0];
      CFG_SECOND_MASK: cfg_mask = val;
      CFG_SWAP:        cfg_swap = val[0];
      default: ;       // unused index is ignored
    endcase
  endtask

  // Mostly well-formed polls (load keys, latch pulse, shift out a run of bits),
  // the rest random noise words.
  task automatic build_phase(int count);
    in_word_t w;
    int       reads;
    int       noise;
    phase_words.delete();
    while (phase_words.size() < count) begin
      if ($urandom_range(0, 9) < 7) begin
        w = make_word(OP_UPDATE);
        case ($urandom_range(0, 7))
          0: w.host_keys = 32'h0000_0000;
          1: w.host_keys = 32'hFFFF_FFFF;
          default: ;
        endcase
        phase_words.push_back(w);
        w = make_word(OP_STROBE);
        w.strobe_bit = 1'b1;
        phase_words.push_back(w);
        if ($urandom_range(0, 3) != 0) begin
          w = make_word(OP_STROBE);
          w.strobe_bit = 1'b0;
          phase_words.push_back(w);
        end
        reads = $urandom_range(8, 20);
        repeat (reads) phase_words.push_back(make_word(OP_READ));
      end else begin
        noise = $urandom_range(1, 4);
        repeat (noise) phase_words.push_back(make_word(2'($urandom_range(0, 3))));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random stalls, score each word against the oldest guess
  // ---------------------------------------------------------------------------
  task automatic score_word(logic [1:0] got);
    logic [1:0] want;
    if (pad_answers.size() == 0) begin
      bad_words++;
      if (bad_words <= 10)
        $display("rsp word with nothing pending: read_data=%0d", got);
    end else begin
      want = pad_answers.pop_front();
      if (got !== want) begin
        bad_words++;
        if (bad_words <= 10)
          $display("read_data mismatch: expected %0d, got %0d", want, got);
      end
    end
  endtask

  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 39) == 0) quiet_rx = !quiet_rx;
      stall = pick_wait(quiet_rx);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      score_word(rsp_ch.data.read_data);
    end
  end

  // Watchdog: a hang shows up as a long run of edges with no traffic at all.
  always @(posedge clk) begin
    if (rst || cfg_we || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck == STUCK_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = CFG_PAD_COUNT;
    cfg_data     = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    req_up       = 1'b0;
    quiet_tx     = 1'b0;
    quiet_rx     = 1'b0;
    bad_words    = 0;
    stuck        = 0;
    cfg_pads     = PadCountReset;
    cfg_mask     = SecondMaskReset;
    cfg_swap     = 1'b0;
    latch_set    = 1'b0;
    sent[0]      = '0;
    sent[1]      = '0;
    for (int n = 0; n < PADS; n++) begin
      host_byte[n] = '0;
      pad_byte[n]  = '0;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed rows against the reset configuration
    foreach (DIRECTED_ROWS[i])
      send_word(DIRECTED_ROWS[i].w, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);
    settle();

    // random phases, registers rewritten only with the block drained
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) begin
        write_reg(CFG_PAD_COUNT, 8'($urandom_range(0, 4)));
        write_reg(CFG_SECOND_MASK, 8'($urandom));
        write_reg(CFG_SWAP, 8'($urandom_range(0, 1)));
      end else begin
        write_reg(CFG_PAD_COUNT, {5'd0, PHASE_PADS[ph]});
        write_reg(CFG_SECOND_MASK, PHASE_MASK[ph]);
        write_reg(CFG_SWAP, {7'd0, PHASE_SWAP[ph]});
      end
      if (ph == 3) write_reg(CFG_UNUSED, 8'hFF);
      build_phase(PHASE_WORDS);
      foreach (phase_words[i]) send_word(phase_words[i], 1'b0, 2'd0);
      settle();
    end

    repeat (4) @(posedge clk);
    if (bad_words == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/gpsp_pkg.sv
hw/rtl/gpsp_chan_if.sv
hw/rtl/gpsp_pad_regs.sv
hw/rtl/gpsp_serial.sv
hw/rtl/game_pad_serial_port_core.sv
tb/game_pad_serial_port_core_tb.sv
